>>> rtl/spd_pkg.sv
`default_nettype none

package spd_pkg;

  // framing bytes
  localparam logic [7:0] HDR0     = 8'd205;
  localparam logic [7:0] HDR1     = 8'd235;
  localparam logic [7:0] HDR2     = 8'd215;
  localparam logic [7:0] SEP_BYTE = 8'd32;

  // packet lengths that produce results
  localparam logic [7:0] LONG_LEN  = 8'd115;
  localparam logic [7:0] SHORT_LEN = 8'd95;

  // word counts and separator checks
  localparam int unsigned IDX_W = 5;
  localparam int unsigned WCNT_W = 6;
  localparam logic [IDX_W-1:0]  LONG_WORDS  = 5'd23;
  localparam logic [IDX_W-1:0]  SHORT_WORDS = 5'd19;
  localparam logic [WCNT_W-1:0] SEP_CHECKS  = 6'd7;

  // word ram: one bank bit over the word index
  localparam int unsigned RAM_AW = IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** RAM_AW;

  // word write from front to the word ram
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } wr_t;

  // finished packet handed from front to back
  typedef struct packed {
    logic bank;
    logic long_pkt;
    logic err;
  } cmd_t;

  // bank handed back from back to front
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  // one result transaction
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic             status;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/spd_front.sv
`default_nettype none

module spd_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  output logic              full,
  input  wire  [7:0]        in_rx_byte,
  output spd_pkg::wr_t      wr,
  output logic              cmd_push,
  output spd_pkg::cmd_t     cmd,
  input  spd_pkg::rel_t     rel
);

  logic [7:0]                   older_r, older_nxt;
  logic [7:0]                   newer_r, newer_nxt;
  logic                         expect_len_r, expect_len_nxt;
  logic [7:0]                   target_len_r, target_len_nxt;
  logic [7:0]                   rcv_cnt_r, rcv_cnt_nxt;
  logic [2:0]                   col_r, col_nxt;
  logic [spd_pkg::WCNT_W-1:0]   widx_r, widx_nxt;
  logic [23:0]                  asm_r, asm_nxt;
  logic                         sep_err_r, sep_err_nxt;
  logic                         wr_bank_r, wr_bank_nxt;
  logic [1:0]                   busy_r, busy_nxt;

  logic accept;
  logic header;
  logic payload;
  logic done;
  logic known;
  logic sep_bad;

  // stall while the bank to be filled still waits for the back end
  assign full   = busy_r[wr_bank_r];
  assign accept = push & ~full;

  // classify the incoming byte
  assign header  = (older_r == spd_pkg::HDR0) && (newer_r == spd_pkg::HDR1) &&
                   (in_rx_byte == spd_pkg::HDR2);
  assign payload = !header && !expect_len_r && (target_len_r > rcv_cnt_r);
  assign done    = payload && (({1'b0, rcv_cnt_r} + 9'd1) == {1'b0, target_len_r});
  assign known   = (target_len_r == spd_pkg::LONG_LEN) ||
                   (target_len_r == spd_pkg::SHORT_LEN);
  assign sep_bad = payload && (col_r == 3'd4) && (widx_r < spd_pkg::SEP_CHECKS) &&
                   (in_rx_byte != spd_pkg::SEP_BYTE);

  // word write on the fourth byte of each group
  assign wr.en   = accept && payload && (col_r == 3'd3) &&
                   (widx_r < {1'b0, spd_pkg::LONG_WORDS});
  assign wr.addr = {wr_bank_r, widx_r[spd_pkg::IDX_W-1:0]};
  assign wr.data = {in_rx_byte, asm_r};

  // packet command on completion of a known length
  assign cmd_push     = accept && done && known;
  assign cmd.bank     = wr_bank_r;
  assign cmd.long_pkt = (target_len_r == spd_pkg::LONG_LEN);
  assign cmd.err      = sep_err_r | sep_bad;

  // next state
  always_comb begin
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    expect_len_nxt = expect_len_r;
    target_len_nxt = target_len_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    col_nxt        = col_r;
    widx_nxt       = widx_r;
    asm_nxt        = asm_r;
    sep_err_nxt    = sep_err_r;
    wr_bank_nxt    = wr_bank_r;
    busy_nxt       = busy_r;
    if (accept) begin
      older_nxt = newer_r;
      newer_nxt = in_rx_byte;
      if (header) begin
        expect_len_nxt = 1'b1;
        target_len_nxt = 8'd0;
        rcv_cnt_nxt    = 8'd0;
        col_nxt        = 3'd0;
        widx_nxt       = '0;
        sep_err_nxt    = 1'b0;
      end else if (expect_len_r) begin
        expect_len_nxt = 1'b0;
        target_len_nxt = in_rx_byte;
      end else if (payload) begin
        rcv_cnt_nxt = rcv_cnt_r + 8'd1;
        sep_err_nxt = sep_err_r | sep_bad;
        case (col_r)
          3'd0: asm_nxt[7:0]   = in_rx_byte;
          3'd1: asm_nxt[15:8]  = in_rx_byte;
          3'd2: asm_nxt[23:16] = in_rx_byte;
          default: asm_nxt = asm_r;
        endcase
        if (col_r == 3'd4) begin
          col_nxt  = 3'd0;
          widx_nxt = widx_r + spd_pkg::WCNT_W'(1);
        end else begin
          col_nxt = col_r + 3'd1;
        end
        if (done) begin
          target_len_nxt = 8'd0;
          rcv_cnt_nxt    = 8'd0;
        end
      end
    end
    // bank bookkeeping
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (cmd_push) begin
      busy_nxt[wr_bank_r] = 1'b1;
      wr_bank_nxt         = ~wr_bank_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r      <= 8'd0;
      newer_r      <= 8'd0;
      expect_len_r <= 1'b0;
      target_len_r <= 8'd0;
      rcv_cnt_r    <= 8'd0;
      col_r        <= 3'd0;
      widx_r       <= '0;
      sep_err_r    <= 1'b0;
      wr_bank_r    <= 1'b0;
      busy_r       <= 2'b00;
    end else begin
      older_r      <= older_nxt;
      newer_r      <= newer_nxt;
      expect_len_r <= expect_len_nxt;
      target_len_r <= target_len_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      col_r        <= col_nxt;
      widx_r       <= widx_nxt;
      sep_err_r    <= sep_err_nxt;
      wr_bank_r    <= wr_bank_nxt;
      busy_r       <= busy_nxt;
    end
  end

  // partial word bytes
  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/spd_cmd_fifo.sv
`default_nettype none

module spd_cmd_fifo (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            wr_en,
  input  spd_pkg::cmd_t  wr_cmd,
  output logic           full,
  input  wire            rd_en,
  output logic           empty,
  output spd_pkg::cmd_t  rd_cmd
);

  spd_pkg::cmd_t q_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r;
  logic          do_wr, do_rd;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign do_wr  = wr_en & ~full;
  assign do_rd  = rd_en & ~empty;
  assign rd_cmd = q_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= ~wptr_r;
      if (do_rd) rptr_r <= ~rptr_r;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) q_r[wptr_r] <= wr_cmd;
  end

endmodule

`default_nettype wire

>>> rtl/spd_back.sv
`default_nettype none

module spd_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  spd_pkg::wr_t              wr,
  input  wire                       cmd_empty,
  input  spd_pkg::cmd_t             cmd_head,
  output logic                      cmd_pop,
  output spd_pkg::rel_t             rel,
  output logic                      empty,
  input  wire                       pop,
  output logic [spd_pkg::IDX_W-1:0] out_word_index,
  output logic [31:0]               out_word_value,
  output logic                      out_packet_status,
  output logic                      out_last_of_packet
);

  logic [31:0]               mem [spd_pkg::RAM_DEPTH];
  logic [31:0]               ram_q_r;

  logic                      run_r;
  logic                      cur_bank_r;
  logic                      cur_long_r;
  logic                      cur_err_r;
  logic [spd_pkg::IDX_W-1:0] k_r;

  logic                      s1_vld_r;
  logic [spd_pkg::IDX_W-1:0] s1_idx_r;
  logic                      s1_err_r;
  logic                      s1_last_r;

  spd_pkg::res_t             of_q_r [2];
  logic                      of_wptr_r, of_rptr_r;
  logic [1:0]                occ_r;

  logic [spd_pkg::IDX_W-1:0] words;
  logic                      pop_fire;
  logic [2:0]                load;
  logic                      issue;
  logic                      last_issue;
  spd_pkg::res_t             s1_res;
  spd_pkg::res_t             head;

  // issue control: keep in-flight plus held results within the output queue
  assign words      = cur_long_r ? spd_pkg::LONG_WORDS : spd_pkg::SHORT_WORDS;
  assign pop_fire   = pop & ~empty;
  assign load       = {1'b0, occ_r} + {2'b00, s1_vld_r} - {2'b00, pop_fire};
  assign issue      = run_r && (load < 3'd2);
  assign last_issue = cur_err_r || (k_r == words - 5'd1);
  assign cmd_pop    = !run_r && !cmd_empty;

  assign rel.en   = issue && last_issue;
  assign rel.bank = cur_bank_r;

  // sequencer over the words of one packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      if (cmd_pop) begin
        run_r <= 1'b1;
      end else if (issue && last_issue) begin
        run_r <= 1'b0;
      end
    end
  end

  // packet fields and read stage payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_bank_r <= cmd_head.bank;
      cur_long_r <= cmd_head.long_pkt;
      cur_err_r  <= cmd_head.err;
      k_r        <= '0;
    end else if (issue) begin
      k_r <= k_r + 5'd1;
    end
    if (issue) begin
      s1_idx_r  <= cur_err_r ? '0 : k_r;
      s1_err_r  <= cur_err_r;
      s1_last_r <= last_issue;
    end
  end

  // word ram, written by the front end
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    if (issue && !cur_err_r) ram_q_r <= mem[{cur_bank_r, k_r}];
  end

  // result assembly
  always_comb begin
    s1_res.idx    = s1_idx_r;
    s1_res.value  = s1_err_r ? 32'd0 : ram_q_r;
    s1_res.status = s1_err_r;
    s1_res.last   = s1_last_r;
  end

  // output queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wptr_r <= 1'b0;
      of_rptr_r <= 1'b0;
      occ_r     <= 2'd0;
    end else begin
      if (s1_vld_r) of_wptr_r <= ~of_wptr_r;
      if (pop_fire) of_rptr_r <= ~of_rptr_r;
      if (s1_vld_r && !pop_fire) begin
        occ_r <= occ_r + 2'd1;
      end else if (pop_fire && !s1_vld_r) begin
        occ_r <= occ_r - 2'd1;
      end
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (s1_vld_r) of_q_r[of_wptr_r] <= s1_res;
  end

  assign head               = of_q_r[of_rptr_r];
  assign empty              = (occ_r == 2'd0);
  assign out_word_index     = head.idx;
  assign out_word_value     = head.value;
  assign out_packet_status  = head.status;
  assign out_last_of_packet = head.last;

endmodule

`default_nettype wire

>>> rtl/status_packet_deframer_unit.sv
// path: a packet's first result reaches the outputs through the command queue, ram read stage and result queue
// throughput: one byte per cycle while full is low; results leave at one per cycle from a 2-entry queue while popped
// bytes stall (full) only while both word ram banks hold packets whose words are not yet all read
// reset: synchronous active-low rst_n clears framing state, command and result queues
// the word ram is not cleared: every word read was written by the same packet
`default_nettype none

module status_packet_deframer_unit (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  output logic                      full,
  input  wire  [7:0]                in_rx_byte,
  output logic                      empty,
  input  wire                       pop,
  output logic [spd_pkg::IDX_W-1:0] out_word_index,
  output logic [31:0]               out_word_value,
  output logic                      out_packet_status,
  output logic                      out_last_of_packet
);

  spd_pkg::wr_t  wr;
  spd_pkg::cmd_t cmd;
  spd_pkg::cmd_t cmd_head;
  spd_pkg::rel_t rel;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;

  // framing, word assembly and separator check
  spd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .wr         (wr),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .rel        (rel)
  );

  // finished packets waiting for emission
  spd_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .empty  (cmd_empty),
    .rd_cmd (cmd_head)
  );

  // word ram and result emission
  spd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr                 (wr),
    .cmd_empty          (cmd_empty),
    .cmd_head           (cmd_head),
    .cmd_pop            (cmd_pop),
    .rel                (rel),
    .empty              (empty),
    .pop                (pop),
    .out_word_index     (out_word_index),
    .out_word_value     (out_word_value),
    .out_packet_status  (out_packet_status),
    .out_last_of_packet (out_last_of_packet)
  );

  // bank tracking must keep the command queue from overflowing
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_push && cmd_full))
    else $error("command pushed into a full queue");

  // no result survives a reset
  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> empty)
    else $error("result queue not empty after reset");

  // an error result is a lone, zeroed transaction
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_packet_status) |->
      (out_last_of_packet && (out_word_index == '0) && (out_word_value == 32'd0)))
    else $error("malformed error result");

  // the front end never writes a bank that is being released
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel.en |-> !(wr.en && (wr.addr[spd_pkg::RAM_AW-1] == rel.bank)))
    else $error("word written into a bank being released");

endmodule

`default_nettype wire

>>> bench/tb_status_packet_deframer_unit.sv
`timescale 1ns / 1ps

module tb_status_packet_deframer_unit;

  localparam int STORE_DEPTH = 128;
  localparam int FULL_PAYLOAD = 1000;
  localparam int HOLD_CYCLES = 500;

  typedef enum logic [1:0] {ROW_BYTE, ROW_PACKET} row_kind_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_ERROR, CHK_MODEL} row_check_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;    // raw byte or payload length
    int         bad_sep;  // separator slot to corrupt, -1 for none
    int         cut;      // payload bytes actually sent
    fill_t      fill;
    row_check_t check;
  } plan_row_t;

  // directed stimulus: raw bytes and packets, one of them cut short
  localparam plan_row_t PLAN [22] = '{
    '{ROW_BYTE,   8'd0,               -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   8'd255,             -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR0,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR1,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR0,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR1,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR2,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   8'd0,               -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_BYTE,   spd_pkg::HDR2,      -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, 8'd3,               -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, 8'd255,             -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, spd_pkg::LONG_LEN,  -1, FULL_PAYLOAD, FILL_ONES,   CHK_MODEL},
    '{ROW_PACKET, spd_pkg::SHORT_LEN, -1, FULL_PAYLOAD, FILL_ZERO,   CHK_MODEL},
    '{ROW_BYTE,   spd_pkg::SEP_BYTE,  -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, spd_pkg::LONG_LEN,  0,  FULL_PAYLOAD, FILL_RANDOM, CHK_ERROR},
    '{ROW_PACKET, spd_pkg::SHORT_LEN, 6,  FULL_PAYLOAD, FILL_RANDOM, CHK_ERROR},
    '{ROW_PACKET, spd_pkg::LONG_LEN,  3,  FULL_PAYLOAD, FILL_ONES,   CHK_ERROR},
    '{ROW_PACKET, spd_pkg::LONG_LEN,  -1, 40,           FILL_RANDOM, CHK_MODEL},
    '{ROW_PACKET, spd_pkg::SHORT_LEN, -1, FULL_PAYLOAD, FILL_RANDOM, CHK_MODEL},
    '{ROW_PACKET, 8'd114,             -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, 8'd96,              -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE},
    '{ROW_PACKET, 8'd1,               -1, FULL_PAYLOAD, FILL_RANDOM, CHK_NONE}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic pop = 1'b0;
  logic full, empty;
  logic [spd_pkg::IDX_W-1:0] out_word_index;
  logic [31:0] out_word_value;
  logic out_packet_status, out_last_of_packet;

  // deframer state mirror
  logic [7:0] hist_old = 8'd0;
  logic [7:0] hist_new = 8'd0;
  logic want_len = 1'b0;
  logic [7:0] pkt_len = 8'd0;
  logic [7:0] pkt_cnt = 8'd0;
  logic [7:0] pkt_bytes [STORE_DEPTH];

  spd_pkg::res_t fresh_words [$];
  spd_pkg::res_t pending_words [$];
  spd_pkg::res_t want;
  logic [7:0] burst [$];
  row_check_t cur_check = CHK_MODEL;
  logic in_acc = 1'b0;
  logic hold_req = 1'b0;
  int quiet_left [2] = '{0, 0};
  int mismatches = 0;
  int bytes_accepted = 0;

  status_packet_deframer_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_rx_byte(in_rx_byte),
    .empty(empty),
    .pop(pop),
    .out_word_index(out_word_index),
    .out_word_value(out_word_value),
    .out_packet_status(out_packet_status),
    .out_last_of_packet(out_last_of_packet)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic spd_pkg::res_t make_res(input logic [spd_pkg::IDX_W-1:0] w_idx,
                                             input logic [31:0] w_val,
                                             input logic w_status, input logic w_last);
    spd_pkg::res_t r;
    r.idx = w_idx;
    r.value = w_val;
    r.status = w_status;
    r.last = w_last;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and quiet stretches with none
  function automatic int pick_gap(input int side);
    int r;
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left[side] = $urandom_range(50, 200);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // advance framing by one byte, collecting the words it releases
  function automatic void deframe_byte(input logic [7:0] b);
    logic hdr;
    logic sep_bad;
    int n_words;
    int j;
    hdr = (hist_old == spd_pkg::HDR0) && (hist_new == spd_pkg::HDR1) &&
          (b == spd_pkg::HDR2);
    hist_old = hist_new;
    hist_new = b;
    if (hdr) begin
      want_len = 1'b1;
      pkt_len = 8'd0;
      pkt_cnt = 8'd0;
    end else if (want_len) begin
      pkt_len = b;
      want_len = 1'b0;
    end else if (pkt_cnt < pkt_len) begin
      if (pkt_cnt < STORE_DEPTH) pkt_bytes[pkt_cnt] = b;
      pkt_cnt = pkt_cnt + 8'd1;
      if (pkt_cnt == pkt_len) begin
        n_words = (pkt_len == spd_pkg::LONG_LEN) ? spd_pkg::LONG_WORDS :
                  (pkt_len == spd_pkg::SHORT_LEN) ? spd_pkg::SHORT_WORDS : 0;
        sep_bad = 1'b0;
        for (j = 0; j < spd_pkg::SEP_CHECKS; j++)
          if (pkt_bytes[5 * j + 4] != spd_pkg::SEP_BYTE) sep_bad = 1'b1;
        if (n_words != 0 && sep_bad) begin
          fresh_words.push_back(make_res('0, '0, 1'b1, 1'b1));
        end else begin
          for (j = 0; j < n_words; j++)
            fresh_words.push_back(make_res(j[spd_pkg::IDX_W-1:0],
                {pkt_bytes[5*j+3], pkt_bytes[5*j+2], pkt_bytes[5*j+1], pkt_bytes[5*j]},
                1'b0, j == n_words - 1));
        end
        pkt_len = 8'd0;
        pkt_cnt = 8'd0;
      end
    end
  endfunction

  // header, length and payload, separators in place but for slot bad_sep
  task automatic build_packet(input int len, input int bad_sep, input int cut,
                              input fill_t fill);
    logic [7:0] b;
    int i;
    burst.push_back(spd_pkg::HDR0);
    burst.push_back(spd_pkg::HDR1);
    burst.push_back(spd_pkg::HDR2);
    burst.push_back(len[7:0]);
    for (i = 0; i < len && i < cut; i++) begin
      b = 8'($urandom_range(0, 254));
      if (b >= spd_pkg::HDR0) b = b + 8'd1;
      if (fill == FILL_ZERO) b = 8'd0;
      if (fill == FILL_ONES) b = 8'd255;
      if (i % 5 == 4 && i / 5 < spd_pkg::SEP_CHECKS) begin
        if (i / 5 != bad_sep) b = spd_pkg::SEP_BYTE;
        else if (b == spd_pkg::SEP_BYTE) b = 8'd0;
      end
      burst.push_back(b);
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) burst.push_back(8'($urandom_range(0, 255)));
  endtask

  // one transaction per byte, gaps in between unless tight
  task automatic send_burst(input row_check_t chk, input bit tight);
    logic [7:0] b;
    int g;
    while (burst.size() != 0) begin
      b = burst.pop_front();
      g = tight ? 0 : pick_gap(0);
      if (g > 0) begin
        push <= 1'b0;
        repeat (g) @(negedge clk);
      end
      push <= 1'b1;
      in_rx_byte <= b;
      cur_check <= chk;
      do @(negedge clk); while (!in_acc);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
  endtask

  // accepted transactions on both sides
  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= push && !full;
      if (push && !full) begin
        fresh_words.delete();
        deframe_byte(in_rx_byte);
        if (cur_check == CHK_MODEL) begin
          foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
        end
        bytes_accepted++;
      end
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual idx %0d value %h %s %0d %s %0d",
                   $time, out_word_index, out_word_value, "status", out_packet_status,
                   "last", out_last_of_packet);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (out_word_index !== want.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.idx, out_word_index);
            mismatches++;
          end
          if (out_word_value !== want.value) begin
            $display("%0t: word_value expected %h actual %h", $time, want.value, out_word_value);
            mismatches++;
          end
          if (out_packet_status !== want.status) begin
            $display("%0t: packet_status expected %0d actual %0d", $time, want.status,
                     out_packet_status);
            mismatches++;
          end
          if (out_last_of_packet !== want.last) begin
            $display("%0t: last_of_packet expected %0d actual %0d", $time, want.last,
                     out_last_of_packet);
            mismatches++;
          end
        end
      end
    end
  end

  // result side: random pops, one long hold on request
  initial begin
    int pop_wait;
    pop_wait = 0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
        pop_wait = pick_gap(1);
      end
    end
  end

  // byte side: directed plan, pressure, then random sequences
  initial begin
    int pick;
    int len;
    int bad;
    int start_bytes;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_BYTE) burst.push_back(PLAN[r].value);
      else build_packet(PLAN[r].value, PLAN[r].bad_sep, PLAN[r].cut, PLAN[r].fill);
      send_burst(PLAN[r].check, 1'b0);
      if (PLAN[r].check == CHK_ERROR) pending_words.push_back(make_res('0, '0, 1'b1, 1'b1));
    end

    // back-to-back packets while the result side holds off
    hold_req = 1'b1;
    repeat (4) begin
      build_packet(spd_pkg::LONG_LEN, -1, FULL_PAYLOAD, FILL_RANDOM);
      send_burst(CHK_MODEL, 1'b1);
    end
    drain_results();

    start_bytes = bytes_accepted;
    while (bytes_accepted < start_bytes + 170) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 1) ? spd_pkg::LONG_LEN : spd_pkg::SHORT_LEN;
      if (pick < 55) begin
        // well-formed packet, sometimes with a bad separator or trailing bytes
        bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : -1;
        build_packet(len, bad, FULL_PAYLOAD, FILL_RANDOM);
        if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 5));
      end else if (pick < 65) begin
        // packet cut short, its remaining payload bytes not sent
        build_packet(len, -1, $urandom_range(0, len - 1), FILL_RANDOM);
      end else if (pick < 75) begin
        len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 140);
        if (len == spd_pkg::LONG_LEN || len == spd_pkg::SHORT_LEN) len++;
        build_packet(len, -1, FULL_PAYLOAD, FILL_RANDOM);
      end else if (pick < 88) begin
        add_noise($urandom_range(1, 8));
      end else begin
        burst.push_back(spd_pkg::HDR0);
        burst.push_back(spd_pkg::HDR1);
        burst.push_back($urandom_range(0, 1) ? spd_pkg::HDR2 : 8'($urandom_range(0, 255)));
      end
      send_burst(CHK_MODEL, 1'b0);
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("PASS status_packet_deframer_unit");
    else $display("FAIL status_packet_deframer_unit");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL status_packet_deframer_unit");
    $finish;
  end

endmodule

>>> sim.f
rtl/spd_pkg.sv
rtl/spd_front.sv
rtl/spd_cmd_fifo.sv
rtl/spd_back.sv
rtl/status_packet_deframer_unit.sv
bench/tb_status_packet_deframer_unit.sv
